FILE: src/vtp_pkg.sv
// Shared types and constants for the view transform and perspective projection.
// Used by the top level, the projection divider and the port checker.
package vtp_pkg;

  // Cycles from an accepted word to its result strobe
  localparam int LATENCY = 26;
  // Quotient bits resolved by the divider, one per stage
  localparam int DIV_STEPS = 16;

  typedef enum logic [2:0] {
    REG_RIGHT_AXIS   = 3'd0,
    REG_UP_AXIS      = 3'd1,
    REG_FORWARD_AXIS = 3'd2,
    REG_CAMERA_ORIG  = 3'd3,
    REG_HORIZ_SCALE  = 3'd4,
    REG_VERT_SCALE   = 3'd5,
    REG_SCREEN_W     = 3'd6,
    REG_SCREEN_H     = 3'd7
  } cfg_reg_t;

  // Fields that ride along with a point through the divider
  typedef struct packed {
    logic               vis;
    logic [19:0]        n;
    logic signed [19:0] vx;
    logic signed [19:0] vy;
    logic signed [19:0] vz;
  } view_info_t;

  // Divider request: both pixel numerators and the point's view data
  typedef struct packed {
    logic signed [50:0] num_x;
    logic signed [50:0] num_y;
    view_info_t         info;
  } div_req_t;

endpackage

FILE: src/view_transform_perspective_project.sv
// Top level: camera view transform and perspective projection pipeline.
// Depends on vtp_pkg and vtp_div.
// Takes one world point per cycle whenever start is high; busy never rises.
// Every point yields one result word, strobed by done for one cycle once
// it has passed seven arithmetic stages (offset, products, sums, saturation,
// focal scale, bias, screen scale) and a 19-stage divider whose restoring
// stages resolve one quotient bit each. Results cannot be held off.
// Configuration words are taken at any time but must only be written while
// no point is in flight.
module view_transform_perspective_project (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [19:0] point_x,
  input  logic signed [19:0] point_y,
  input  logic signed [19:0] point_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [59:0]        cfg_data,
  output logic               done,
  output logic               visible,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic signed [19:0] view_x,
  output logic signed [19:0] view_y,
  output logic signed [19:0] view_z
);

  logic [47:0] right_axis;
  logic [47:0] up_axis;
  logic [47:0] forward_axis;
  logic [59:0] camera_origin;
  logic [15:0] horizontal_scale;
  logic [15:0] vertical_scale;
  logic [11:0] screen_width;
  logic [11:0] screen_height;

  logic [6:0] v;
  logic signed [20:0] d [3];
  logic signed [36:0] pr [3];
  logic signed [36:0] pu [3];
  logic signed [36:0] pf [3];
  logic signed [39:0] sx_sum;
  logic signed [39:0] sy_sum;
  logic signed [39:0] sz_sum;
  vtp_pkg::view_info_t info4;
  vtp_pkg::view_info_t info5;
  vtp_pkg::view_info_t info6;
  logic signed [36:0] mx;
  logic signed [36:0] my;
  logic signed [37:0] ax;
  logic signed [37:0] ay;
  vtp_pkg::div_req_t req;
  logic signed [19:0] vx_next;
  logic signed [19:0] vy_next;
  logic signed [19:0] vz_next;
  vtp_pkg::view_info_t div_info;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      right_axis       <= 48'h0000_0000_4000;
      up_axis          <= 48'h0000_4000_0000;
      forward_axis     <= 48'hC000_0000_0000;
      camera_origin    <= '0;
      horizontal_scale <= 16'd256;
      vertical_scale   <= 16'd256;
      screen_width     <= 12'd640;
      screen_height    <= 12'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (vtp_pkg::cfg_reg_t'(cfg_index))
        vtp_pkg::REG_RIGHT_AXIS:   right_axis       <= cfg_data[47:0];
        vtp_pkg::REG_UP_AXIS:      up_axis          <= cfg_data[47:0];
        vtp_pkg::REG_FORWARD_AXIS: forward_axis     <= cfg_data[47:0];
        vtp_pkg::REG_CAMERA_ORIG:  camera_origin    <= cfg_data;
        vtp_pkg::REG_HORIZ_SCALE:  horizontal_scale <= cfg_data[15:0];
        vtp_pkg::REG_VERT_SCALE:   vertical_scale   <= cfg_data[15:0];
        vtp_pkg::REG_SCREEN_W:     screen_width     <= cfg_data[11:0];
        vtp_pkg::REG_SCREEN_H:     screen_height    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Advance valid bits; the pipeline never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[5:0], start && !busy};
    end
  end

  // Stage 1: offset from the camera origin
  always_ff @(posedge clk) begin
    d[0] <= 21'(point_x) - 21'($signed(camera_origin[19:0]));
    d[1] <= 21'(point_y) - 21'($signed(camera_origin[39:20]));
    d[2] <= 21'(point_z) - 21'($signed(camera_origin[59:40]));
  end

  // Stage 2: component products with each axis
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr[i] <= d[i] * $signed(right_axis[16*i +: 16]);
      pu[i] <= d[i] * $signed(up_axis[16*i +: 16]);
      pf[i] <= d[i] * $signed(forward_axis[16*i +: 16]);
    end
  end

  // Stage 3: dot products, forward one negated
  always_ff @(posedge clk) begin
    sx_sum <= 40'(pr[0]) + 40'(pr[1]) + 40'(pr[2]);
    sy_sum <= 40'(pu[0]) + 40'(pu[1]) + 40'(pu[2]);
    sz_sum <= 40'sd0 - (40'(pf[0]) + 40'(pf[1]) + 40'(pf[2]));
  end

  function automatic logic signed [19:0] floor_sat(input logic signed [39:0] s);
    logic signed [25:0] t;
    t = s[39:14];
    if (t > 26'sd524287) begin
      floor_sat = 20'sh7FFFF;
    end else if (t < -26'sd524288) begin
      floor_sat = 20'sh80000;
    end else begin
      floor_sat = t[19:0];
    end
  endfunction

  // Stage 4: scale down, saturate, decide visibility
  always_comb begin
    vx_next = floor_sat(sx_sum);
    vy_next = floor_sat(sy_sum);
    vz_next = floor_sat(sz_sum);
  end

  always_ff @(posedge clk) begin
    info4.vx  <= vx_next;
    info4.vy  <= vy_next;
    info4.vz  <= vz_next;
    info4.vis <= vz_next[19];
    info4.n   <= 20'(0 - vz_next);
  end

  // Stage 5: focal scale
  always_ff @(posedge clk) begin
    mx    <= info4.vx * $signed({1'b0, horizontal_scale});
    my    <= info4.vy * $signed({1'b0, vertical_scale});
    info5 <= info4;
  end

  // Stage 6: add the half-screen bias
  always_ff @(posedge clk) begin
    ax    <= 38'(mx) + $signed({10'b0, info5.n, 8'b0});
    ay    <= $signed({10'b0, info5.n, 8'b0}) - 38'(my);
    info6 <= info5;
  end

  // Stage 7: screen scale
  always_ff @(posedge clk) begin
    req.num_x <= ax * $signed({1'b0, screen_width});
    req.num_y <= ay * $signed({1'b0, screen_height});
    req.info  <= info6;
  end

  vtp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[6]),
    .in_req    (req),
    .out_valid (done),
    .out_x     (screen_x),
    .out_y     (screen_y),
    .out_info  (div_info)
  );

  assign visible = div_info.vis;
  assign view_x  = div_info.vx;
  assign view_y  = div_info.vy;
  assign view_z  = div_info.vz;

endmodule

FILE: src/vtp_div.sv
// Pipelined projection divider: |num| / (512 * n), truncated toward zero,
// saturated to 16 bits, one quotient bit per stage. Depends on vtp_pkg.
module vtp_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  vtp_pkg::div_req_t   in_req,
  output logic                out_valid,
  output logic signed [15:0]  out_x,
  output logic signed [15:0]  out_y,
  output vtp_pkg::view_info_t out_info
);

  typedef struct packed {
    logic               neg_x;
    logic               neg_y;
    logic [41:0]        mag_x;
    logic [41:0]        mag_y;
    vtp_pkg::view_info_t info;
  } abs_stage_t;

  typedef struct packed {
    logic               neg_x;
    logic               neg_y;
    logic               ovf_x;
    logic               ovf_y;
    logic [35:0]        rem_x;
    logic [35:0]        rem_y;
    logic [15:0]        q_x;
    logic [15:0]        q_y;
    vtp_pkg::view_info_t info;
  } step_stage_t;

  logic        abs_valid;
  abs_stage_t  abs_q;
  logic [vtp_pkg::DIV_STEPS:0] st_valid;
  step_stage_t st [vtp_pkg::DIV_STEPS+1];
  step_stage_t st_next [vtp_pkg::DIV_STEPS];
  step_stage_t first_next;
  logic [50:0] abs_x;
  logic [50:0] abs_y;
  logic [41:0] lim;
  logic signed [15:0] res_x_next;
  logic signed [15:0] res_y_next;

  // Take magnitudes and drop the factor 512 of the divisor
  always_comb begin
    abs_x = in_req.num_x[50] ? 51'(-in_req.num_x) : 51'(in_req.num_x);
    abs_y = in_req.num_y[50] ? 51'(-in_req.num_y) : 51'(in_req.num_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_valid <= 1'b0;
    end else begin
      abs_valid <= in_valid;
    end
    abs_q.neg_x <= in_req.num_x[50];
    abs_q.neg_y <= in_req.num_y[50];
    abs_q.mag_x <= abs_x[50:9];
    abs_q.mag_y <= abs_y[50:9];
    abs_q.info  <= in_req.info;
  end

  // Flag quotients that do not fit in 16 bits
  always_comb begin
    lim = {6'b0, abs_q.info.n, 16'b0};
    first_next.neg_x = abs_q.neg_x;
    first_next.neg_y = abs_q.neg_y;
    first_next.ovf_x = abs_q.mag_x >= lim;
    first_next.ovf_y = abs_q.mag_y >= lim;
    first_next.rem_x = abs_q.mag_x[35:0];
    first_next.rem_y = abs_q.mag_y[35:0];
    first_next.q_x   = '0;
    first_next.q_y   = '0;
    first_next.info  = abs_q.info;
  end

  // Restoring steps, most significant quotient bit first
  always_comb begin
    logic [35:0] dv;
    for (int k = 0; k < vtp_pkg::DIV_STEPS; k++) begin
      st_next[k] = st[k];
      dv = {16'b0, st[k].info.n} << (vtp_pkg::DIV_STEPS - 1 - k);
      if (st[k].rem_x >= dv) begin
        st_next[k].rem_x = st[k].rem_x - dv;
        st_next[k].q_x[vtp_pkg::DIV_STEPS - 1 - k] = 1'b1;
      end
      if (st[k].rem_y >= dv) begin
        st_next[k].rem_y = st[k].rem_y - dv;
        st_next[k].q_y[vtp_pkg::DIV_STEPS - 1 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else begin
      st_valid <= {st_valid[vtp_pkg::DIV_STEPS-1:0], abs_valid};
    end
    st[0] <= first_next;
    for (int k = 0; k < vtp_pkg::DIV_STEPS; k++) begin
      st[k+1] <= st_next[k];
    end
  end

  // Apply sign, saturate, force -1 when behind the camera
  always_comb begin
    step_stage_t f;
    f = st[vtp_pkg::DIV_STEPS];
    if (!f.neg_x) begin
      res_x_next = (f.ovf_x || f.q_x[15]) ? 16'sh7FFF : $signed(f.q_x);
    end else begin
      res_x_next = (f.ovf_x || f.q_x > 16'h8000) ? 16'sh8000 : $signed(16'(0 - f.q_x));
    end
    if (!f.neg_y) begin
      res_y_next = (f.ovf_y || f.q_y[15]) ? 16'sh7FFF : $signed(f.q_y);
    end else begin
      res_y_next = (f.ovf_y || f.q_y > 16'h8000) ? 16'sh8000 : $signed(16'(0 - f.q_y));
    end
    if (!f.info.vis) begin
      res_x_next = -16'sd1;
      res_y_next = -16'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= st_valid[vtp_pkg::DIV_STEPS];
    end
    out_x    <= res_x_next;
    out_y    <= res_y_next;
    out_info <= st[vtp_pkg::DIV_STEPS].info;
  end

endmodule

FILE: src/vtp_checker.sv
// Port-level checker for the projection top level, with its bind.
// Depends on vtp_pkg.
module vtp_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               visible,
  input logic signed [15:0] screen_x,
  input logic signed [15:0] screen_y,
  input logic signed [19:0] view_z
);

  // Each accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(vtp_pkg::LATENCY) done)
    else $error("accepted word did not complete on time");

  // No result without a matching accept
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, vtp_pkg::LATENCY))
    else $error("result without an accepted word");

  // Hidden points report -1 on both screen axes
  a_hidden: assert property (@(posedge clk) disable iff (rst)
    (done && !visible) |-> (screen_x == -16'sd1 && screen_y == -16'sd1))
    else $error("hidden point with screen coordinates");

  // Visibility follows the sign of view z
  a_vis_sign: assert property (@(posedge clk) disable iff (rst)
    done |-> (visible == view_z[19]))
    else $error("visibility disagrees with view z");

endmodule

bind view_transform_perspective_project vtp_checker u_vtp_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .visible  (visible),
  .screen_x (screen_x),
  .screen_y (screen_y),
  .view_z   (view_z)
);

FILE: verif/tb_view_transform_perspective_project.sv
// Testbench for the camera view transform and perspective projection block.
// Depends on vtp_pkg and the RTL top level; a scoreboard class predicts each
// result word from the accepted point and the current camera registers.
module tb_view_transform_perspective_project;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [19:0] view_x;
    logic signed [19:0] view_y;
    logic signed [19:0] view_z;
  } projection_t;

  class projection_scoreboard;
    logic [47:0] right_axis, up_axis, forward_axis;
    logic [59:0] camera_origin;
    logic [15:0] horizontal_scale, vertical_scale;
    logic [11:0] screen_width, screen_height;
    projection_t expected_q[$];
    int mismatches;

    function new();
      right_axis = 48'd16384;
      up_axis = 48'd1073741824;
      forward_axis = 48'd211106232532992;
      camera_origin = '0;
      horizontal_scale = 16'd256;
      vertical_scale = 16'd256;
      screen_width = 12'd640;
      screen_height = 12'd480;
      mismatches = 0;
    endfunction

    // Mirror a register word written into the block
    function void write_reg(vtp_pkg::cfg_reg_t idx, logic [59:0] data);
      case (idx)
        vtp_pkg::REG_RIGHT_AXIS:   right_axis = data[47:0];
        vtp_pkg::REG_UP_AXIS:      up_axis = data[47:0];
        vtp_pkg::REG_FORWARD_AXIS: forward_axis = data[47:0];
        vtp_pkg::REG_CAMERA_ORIG:  camera_origin = data;
        vtp_pkg::REG_HORIZ_SCALE:  horizontal_scale = data[15:0];
        vtp_pkg::REG_VERT_SCALE:   vertical_scale = data[15:0];
        vtp_pkg::REG_SCREEN_W:     screen_width = data[11:0];
        vtp_pkg::REG_SCREEN_H:     screen_height = data[11:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Dot product of the offset with one packed axis, floored by 2^14
    function longint axis_product(longint d[3], logic [47:0] axis, bit negate);
      longint acc;
      longint c;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        c = longint'($signed(axis[16*i +: 16]));
        if (negate) c = -c;
        acc += d[i] * c;
      end
      return clamp(acc >>> 14, -524288, 524287);
    endfunction

    // Predict the projection of an accepted point
    function void note_point(logic [19:0] px, logic [19:0] py, logic [19:0] pz);
      longint d[3];
      longint vx, vy, vz, n, numx, numy;
      projection_t e;
      d[0] = longint'($signed(px)) - longint'($signed(camera_origin[19:0]));
      d[1] = longint'($signed(py)) - longint'($signed(camera_origin[39:20]));
      d[2] = longint'($signed(pz)) - longint'($signed(camera_origin[59:40]));
      vx = axis_product(d, right_axis, 1'b0);
      vy = axis_product(d, up_axis, 1'b0);
      vz = axis_product(d, forward_axis, 1'b1);
      e.view_x = vx[19:0];
      e.view_y = vy[19:0];
      e.view_z = vz[19:0];
      e.visible = 1'b0;
      e.screen_x = -16'sd1;
      e.screen_y = -16'sd1;
      if (vz < 0) begin
        n = -vz;
        numx = (vx * longint'(horizontal_scale) + 256 * n) * longint'(screen_width);
        numy = (256 * n - vy * longint'(vertical_scale)) * longint'(screen_height);
        e.visible = 1'b1;
        e.screen_x = 16'(clamp(numx / (512 * n), -32768, 32767));
        e.screen_y = 16'(clamp(numy / (512 * n), -32768, 32767));
      end
      expected_q.push_back(e);
    endfunction

    // Compare one strobed result word with the oldest prediction
    function void check_result(projection_t got);
      projection_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word vis=%0b", got.visible);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp vis=%0b sx=%0d sy=%0d vx=%0d vy=%0d vz=%0d",
                    " | got vis=%0b sx=%0d sy=%0d vx=%0d vy=%0d vz=%0d"},
                   e.visible, e.screen_x, e.screen_y, e.view_x, e.view_y, e.view_z,
                   got.visible, got.screen_x, got.screen_y, got.view_x, got.view_y,
                   got.view_z);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [19:0] point_x = '0, point_y = '0, point_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [59:0] cfg_data = '0;
  logic done, visible;
  logic signed [15:0] screen_x, screen_y;
  logic signed [19:0] view_x, view_y, view_z;

  projection_scoreboard sb = new();
  bit idling = 1'b1;
  int quiet_cycles = 0;

  view_transform_perspective_project uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watch accepted points and result words; stop a stalled run
  always @(posedge clk) begin
    projection_t got;
    bit active;
    if (!rst) begin
      active = 1'b0;
      if (start && !busy) begin
        sb.note_point(point_x, point_y, point_z);
        active = 1'b1;
      end
      if (done) begin
        got.visible = visible;
        got.screen_x = screen_x;
        got.screen_y = screen_y;
        got.view_x = view_x;
        got.view_y = view_y;
        got.view_z = view_z;
        sb.check_result(got);
        active = 1'b1;
      end
      if (cfg_valid && cfg_ready) active = 1'b1;
      quiet_cycles <= active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drive one point word and hold it until taken
  task automatic send_point(logic [19:0] x, logic [19:0] y, logic [19:0] z);
    @(negedge clk);
    while (idling && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write one register word; only called while nothing is in flight
  task automatic write_reg(vtp_pkg::cfg_reg_t idx, logic [59:0] data);
    @(negedge clk);
    start <= 1'b0;
    while (idling && $urandom_range(99) < 38) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lower start, wait for every predicted word, then beyond the pipeline depth
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (vtp_pkg::LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_coord(bit narrow);
    if (narrow) return 20'($signed($urandom_range(0, 8191)) - 4096);
    return 20'($urandom);
  endfunction

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(3))
      0: return 16'd16384;
      1: return 16'hC000;
      2: return 16'($urandom_range(0, 11585));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_points(int count, bit narrow);
    bit nar;
    for (int i = 0; i < count; i++) begin
      nar = narrow && ($urandom_range(3) != 0);
      send_point(rand_coord(nar), rand_coord(nar), rand_coord(nar));
    end
  endtask

  task automatic random_camera();
    write_reg(vtp_pkg::REG_RIGHT_AXIS, {12'd0, rand_comp(), rand_comp(), rand_comp()});
    write_reg(vtp_pkg::REG_UP_AXIS, {12'd0, rand_comp(), rand_comp(), rand_comp()});
    write_reg(vtp_pkg::REG_FORWARD_AXIS, {12'd0, rand_comp(), rand_comp(), rand_comp()});
    write_reg(vtp_pkg::REG_CAMERA_ORIG, {$urandom_range(1) ? 20'($urandom) : 20'd0,
                                         20'($urandom), 20'($urandom)} & {60{1'b1}});
    write_reg(vtp_pkg::REG_HORIZ_SCALE, 60'($urandom_range(0, 65535)));
    write_reg(vtp_pkg::REG_VERT_SCALE, 60'($urandom_range(0, 65535)));
    write_reg(vtp_pkg::REG_SCREEN_W, 60'($urandom_range(1, 4095)));
    write_reg(vtp_pkg::REG_SCREEN_H, 60'($urandom_range(1, 4095)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, origin, behind and on the camera plane
    send_point(20'h00000, 20'h00000, 20'h00000);
    send_point(20'h7FFFF, 20'h7FFFF, 20'h80000);
    send_point(20'h80000, 20'h80000, 20'h80000);
    send_point(20'h7FFFF, 20'h80000, 20'h7FFFF);
    send_point(20'h00100, 20'h00100, 20'hFFF00);
    send_point(20'h00100, 20'hFFF00, 20'h00100);
    send_point(20'h00000, 20'h00000, 20'hFFFFF);
    send_point(20'h7FFFF, 20'h00000, 20'hFFFFF);
    send_point(20'h80000, 20'h7FFFF, 20'hFFFFF);
    send_point(20'h00500, 20'hFFB00, 20'hFF000);
    drain();

    // Extreme camera: all-ones, minimum and maximum axes, far origin, edge scales
    write_reg(vtp_pkg::REG_RIGHT_AXIS, 60'hFFFF_FFFF_FFFF);
    write_reg(vtp_pkg::REG_UP_AXIS, 60'h8000_8000_8000);
    write_reg(vtp_pkg::REG_FORWARD_AXIS, 60'h7FFF_7FFF_7FFF);
    write_reg(vtp_pkg::REG_CAMERA_ORIG, {20'h80000, 20'h7FFFF, 20'h80000});
    write_reg(vtp_pkg::REG_HORIZ_SCALE, 60'hFFFF);
    write_reg(vtp_pkg::REG_VERT_SCALE, 60'h0000);
    write_reg(vtp_pkg::REG_SCREEN_W, 60'd4095);
    write_reg(vtp_pkg::REG_SCREEN_H, 60'd1);
    send_point(20'h7FFFF, 20'h80000, 20'h7FFFF);
    send_point(20'h80000, 20'h7FFFF, 20'h80000);
    send_point(20'h00000, 20'h00000, 20'h00000);
    send_point(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    random_points(20, 1'b0);
    drain();

    // Random cameras, one stretch with no idling at all
    for (int phase = 0; phase < 7; phase++) begin
      idling = (phase != 3);
      random_camera();
      random_points(50, phase[0]);
      drain();
    end
    idling = 1'b1;

    // Back to a plain camera for in-range pixel coordinates
    write_reg(vtp_pkg::REG_RIGHT_AXIS, 60'd16384);
    write_reg(vtp_pkg::REG_UP_AXIS, 60'd1073741824);
    write_reg(vtp_pkg::REG_FORWARD_AXIS, 60'd211106232532992);
    write_reg(vtp_pkg::REG_CAMERA_ORIG, 60'd0);
    write_reg(vtp_pkg::REG_HORIZ_SCALE, 60'd256);
    write_reg(vtp_pkg::REG_VERT_SCALE, 60'd256);
    write_reg(vtp_pkg::REG_SCREEN_W, 60'd640);
    write_reg(vtp_pkg::REG_SCREEN_H, 60'd480);
    random_points(30, 1'b1);
    drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
